### hw/rtl/lcwd_pkg.sv
package lcwd_pkg;

    localparam int HIST_DEPTH = 65536;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int PCOUNT_W   = 17;

    localparam logic [PCOUNT_W-1:0] PCOUNT_MAX = 17'h1FFFF;
    localparam logic [PCOUNT_W-1:0] DEPTH_LIM  = PCOUNT_W'(HIST_DEPTH);

    localparam logic       CMD_BYTE = 1'b0;
    localparam logic       CMD_TICK = 1'b1;

    localparam logic [7:0] OP_END      = 8'h80;
    localparam logic [7:0] OP_FILL     = 8'hFE;
    localparam logic [7:0] OP_LONG     = 8'hFF;
    localparam logic [7:0] MASK_TOP2   = 8'hC0;
    localparam logic [7:0] TOP2_LIT    = 8'h80;
    localparam logic [7:0] MASK_COUNT6 = 8'h3F;
    localparam logic [7:0] MASK_SCOUNT = 8'h70;
    localparam logic [7:0] MASK_SPOS   = 8'h0F;
    localparam logic [7:0] MIN_COPY    = 8'd3;

    typedef enum logic [3:0] {
        PH_FIRST = 4'd0,
        PH_CMD   = 4'd1,
        PH_LIT   = 4'd2,
        PH_SPOS  = 4'd3,
        PH_FC0   = 4'd4,
        PH_FC1   = 4'd5,
        PH_FV    = 4'd6,
        PH_LC0   = 4'd7,
        PH_LC1   = 4'd8,
        PH_LP0   = 4'd9,
        PH_LP1   = 4'd10,
        PH_MP0   = 4'd11,
        PH_MP1   = 4'd12,
        PH_COPY  = 4'd13,
        PH_FILL  = 4'd14
    } phase_t;

    typedef enum logic [2:0] {
        KIND_DATA   = 3'd0,
        KIND_END    = 3'd1,
        KIND_NONE   = 3'd2,
        KIND_BUSY   = 3'd3,
        KIND_BADREF = 3'd4
    } kind_t;

    // What the decode stage hands to the history stage for one request.
    typedef struct packed {
        kind_t              kind;
        logic               from_mem;
        logic [7:0]         byte_val;
        logic               wr_en;
        logic [HIST_AW-1:0] wr_addr;
    } s1_req_t;

endpackage

### hw/rtl/lcwd_ram.sv
module lcwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ram_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= ram_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/lcwd_ctrl.sv
module lcwd_ctrl
    import lcwd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic               cmd,
    input  logic [7:0]         in_byte,
    input  logic               last,
    output s1_req_t            req,
    output logic [HIST_AW-1:0] rd_addr
);

    phase_t              phase_reg, phase_next;
    logic                relative_reg, relative_next;
    logic [15:0]         run_count_reg, run_count_next;
    logic [PCOUNT_W-1:0] run_source_reg, run_source_next;
    logic [PCOUNT_W-1:0] produced_reg, produced_next;
    logic [7:0]          fill_reg, fill_next;
    logic                last_seen_reg, last_seen_next;

    logic [PCOUNT_W-1:0] distance;
    logic                pc_full;
    logic                bad_src;
    logic                end_frame;

    // A position that is counted back from the output so far, or taken as is.
    function automatic logic [PCOUNT_W-1:0] source_from(
        input logic [15:0]         pos,
        input logic                rel,
        input logic [PCOUNT_W-1:0] pc
    );
        logic [PCOUNT_W-1:0] pos_w;
        logic [PCOUNT_W-1:0] result;
        pos_w = PCOUNT_W'(pos);
        if (!rel) begin
            result = pos_w;
        end else if (pos_w <= pc) begin
            result = pc - pos_w;
        end else begin
            result = PCOUNT_MAX;
        end
        return result;
    endfunction

    assign distance = produced_reg - run_source_reg;
    assign pc_full  = (produced_reg >= PCOUNT_MAX);
    assign bad_src  = (run_source_reg >= produced_reg) || (distance > DEPTH_LIM);
    assign rd_addr  = run_source_reg[HIST_AW-1:0];

    always_comb begin
        phase_next      = phase_reg;
        relative_next   = relative_reg;
        run_count_next  = run_count_reg;
        run_source_next = run_source_reg;
        produced_next   = produced_reg;
        fill_next       = fill_reg;
        last_seen_next  = last_seen_reg;
        end_frame       = 1'b0;
        req.kind        = KIND_NONE;
        req.from_mem    = 1'b0;
        req.byte_val    = 8'h00;
        req.wr_en       = 1'b0;
        req.wr_addr     = produced_reg[HIST_AW-1:0];

        if (cmd == CMD_TICK) begin
            if (phase_reg == PH_CMD && last_seen_reg) begin
                end_frame = 1'b1;
                req.kind  = KIND_END;
            end else if (phase_reg == PH_COPY || phase_reg == PH_FILL) begin
                if ((phase_reg == PH_COPY && bad_src) || pc_full) begin
                    run_count_next = 16'd0;
                    phase_next     = PH_CMD;
                    req.kind       = KIND_BADREF;
                end else begin
                    req.kind       = KIND_DATA;
                    req.from_mem   = (phase_reg == PH_COPY);
                    req.byte_val   = fill_reg;
                    req.wr_en      = 1'b1;
                    produced_next  = produced_reg + PCOUNT_W'(1);
                    run_count_next = run_count_reg - 16'd1;
                    if (phase_reg == PH_COPY) begin
                        run_source_next = run_source_reg + PCOUNT_W'(1);
                    end
                    if (run_count_reg == 16'd1) begin
                        phase_next = PH_CMD;
                    end
                end
            end
        end else if (phase_reg == PH_COPY || phase_reg == PH_FILL
                     || (phase_reg == PH_CMD && last_seen_reg)) begin
            req.kind = KIND_BUSY;
        end else if (phase_reg == PH_FIRST || phase_reg == PH_CMD) begin
            if (phase_reg == PH_FIRST && in_byte == 8'h00) begin
                if (last) begin
                    end_frame = 1'b1;
                    req.kind  = KIND_END;
                end else begin
                    relative_next = 1'b1;
                    phase_next    = PH_CMD;
                end
            end else if (last || in_byte == OP_END) begin
                end_frame = 1'b1;
                req.kind  = KIND_END;
            end else if ((in_byte & MASK_TOP2) == TOP2_LIT) begin
                run_count_next = {8'h00, in_byte & MASK_COUNT6};
                phase_next     = ((in_byte & MASK_COUNT6) == 8'h00) ? PH_CMD : PH_LIT;
            end else if (!in_byte[7]) begin
                run_count_next  = {8'h00, ((in_byte & MASK_SCOUNT) >> 4) + MIN_COPY};
                run_source_next = PCOUNT_W'(in_byte & MASK_SPOS);
                phase_next      = PH_SPOS;
            end else if (in_byte == OP_FILL) begin
                phase_next = PH_FC0;
            end else if (in_byte == OP_LONG) begin
                phase_next = PH_LC0;
            end else begin
                run_count_next = {8'h00, (in_byte & MASK_COUNT6) + MIN_COPY};
                phase_next     = PH_MP0;
            end
        end else begin
            if (last) begin
                last_seen_next = 1'b1;
            end
            unique case (phase_reg)
                PH_LIT: begin
                    if (pc_full) begin
                        req.kind = KIND_BADREF;
                    end else begin
                        req.kind      = KIND_DATA;
                        req.byte_val  = in_byte;
                        req.wr_en     = 1'b1;
                        produced_next = produced_reg + PCOUNT_W'(1);
                    end
                    run_count_next = run_count_reg - 16'd1;
                    if (run_count_reg == 16'd1) begin
                        phase_next = PH_CMD;
                    end
                end
                PH_SPOS: begin
                    run_source_next = source_from({4'h0, run_source_reg[3:0], in_byte},
                                                  1'b1, produced_reg);
                    phase_next = (run_count_reg == 16'd0) ? PH_CMD : PH_COPY;
                end
                PH_FC0, PH_LC0: begin
                    run_count_next = {8'h00, in_byte};
                    phase_next     = (phase_reg == PH_FC0) ? PH_FC1 : PH_LC1;
                end
                PH_FC1, PH_LC1: begin
                    run_count_next = {in_byte, run_count_reg[7:0]};
                    phase_next     = (phase_reg == PH_FC1) ? PH_FV : PH_LP0;
                end
                PH_FV: begin
                    fill_next  = in_byte;
                    phase_next = (run_count_reg == 16'd0) ? PH_CMD : PH_FILL;
                end
                PH_LP0, PH_MP0: begin
                    run_source_next = PCOUNT_W'(in_byte);
                    phase_next      = (phase_reg == PH_LP0) ? PH_LP1 : PH_MP1;
                end
                PH_LP1, PH_MP1: begin
                    run_source_next = source_from({in_byte, run_source_reg[7:0]},
                                                  relative_reg, produced_reg);
                    phase_next = (run_count_reg == 16'd0) ? PH_CMD : PH_COPY;
                end
                default: begin
                    end_frame = 1'b1;
                end
            endcase
        end

        if (end_frame) begin
            phase_next      = PH_FIRST;
            relative_next   = 1'b0;
            run_count_next  = 16'd0;
            run_source_next = '0;
            produced_next   = '0;
            fill_next       = 8'h00;
            last_seen_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_FIRST;
            relative_reg   <= 1'b0;
            run_count_reg  <= 16'd0;
            run_source_reg <= '0;
            produced_reg   <= '0;
            fill_reg       <= 8'h00;
            last_seen_reg  <= 1'b0;
        end else if (accept) begin
            phase_reg      <= phase_next;
            relative_reg   <= relative_next;
            run_count_reg  <= run_count_next;
            run_source_reg <= run_source_next;
            produced_reg   <= produced_next;
            fill_reg       <= fill_next;
            last_seen_reg  <= last_seen_next;
        end
    end

`ifndef SYNTH
    a_first_is_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_FIRST |-> produced_reg == '0 && !relative_reg && !last_seen_reg)
        else $error("frame start with leftover frame state");

    a_run_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_COPY || phase_reg == PH_FILL) |-> run_count_reg != 16'd0)
        else $error("pending run with zero count");

    a_write_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && req.wr_en) |=> produced_reg == $past(produced_reg) + PCOUNT_W'(1))
        else $error("history write without output count step");
`endif

endmodule

### hw/rtl/lcwd_resolve.sv
module lcwd_resolve
    import lcwd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  s1_req_t            req,
    input  logic [HIST_AW-1:0] rd_addr,
    input  logic [7:0]         mem_rd_data,
    output logic               in_ready,
    output logic               mem_we,
    output logic [HIST_AW-1:0] mem_waddr,
    output logic [7:0]         mem_wdata,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_kind,
    output logic [7:0]         m_byte
);

    logic       s1_valid_reg;
    s1_req_t    s1_reg;
    logic       byp_hit_reg;
    logic [7:0] byp_data_reg;
    logic       m_valid_reg;
    logic [2:0] m_kind_reg;
    logic [7:0] m_byte_reg;

    logic       m_can;
    logic       s1_move;
    logic       byp_hit_next;
    logic [7:0] value;

    assign m_can    = !m_valid_reg || m_ready;
    assign s1_move  = s1_valid_reg && m_can;
    assign in_ready = !s1_valid_reg || m_can;

    // A read issued while the entry is being written sees the write data.
    assign value = !s1_reg.from_mem ? s1_reg.byte_val
                 : (byp_hit_reg ? byp_data_reg : mem_rd_data);

    assign mem_we       = s1_move && s1_reg.wr_en;
    assign mem_waddr    = s1_reg.wr_addr;
    assign mem_wdata    = value;
    assign byp_hit_next = mem_we && (rd_addr == s1_reg.wr_addr);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= accept || (s1_valid_reg && !m_can);
            if (m_can) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg       <= req;
            byp_hit_reg  <= byp_hit_next;
            byp_data_reg <= value;
        end
        if (s1_move) begin
            m_kind_reg <= s1_reg.kind;
            m_byte_reg <= (s1_reg.kind == KIND_DATA) ? value : 8'h00;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_kind  = m_kind_reg;
    assign m_byte  = m_byte_reg;

`ifndef SYNTH
    a_write_on_move: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> s1_valid_reg && m_can)
        else $error("history written by a stalled request");

    a_byte_only_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_kind_reg != KIND_DATA) |-> m_byte_reg == 8'h00)
        else $error("nonzero byte on a non-data result");

    a_stall_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_ready |-> s1_valid_reg && m_valid_reg && !m_ready)
        else $error("input held off without a full pipeline");
`endif

endmodule

### hw/rtl/lcw_decompressor_core.sv
// Channel  Direction  tdata             tuser      tlast
// s_       in         [7:0] in_byte     [0] cmd    last
// m_       out        [7:0] out_byte    [2:0] kind none
//
// One request is taken per cycle while s_tready is high. Decode and the history read load the
// history stage when a request is accepted, and the output register loads from the history
// stage once it is free, so m_tvalid rises after the request has passed both registers.
// The history memory is read and written once per cycle, and a copy that
// reads the byte being written in the same cycle takes it from a bypass.
// Reset is synchronous and clears control state only; history is never cleared.
// A stalled output holds one result in the output register and one in the
// history stage before s_tready drops.
module lcw_decompressor_core
    import lcwd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic [0:0] s_tuser,   // [0] cmd
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [2:0] m_tuser    // [2:0] kind
);

    logic               accept;
    s1_req_t            req;
    logic [HIST_AW-1:0] rd_addr;
    logic [7:0]         rd_data;
    logic               mem_we;
    logic [HIST_AW-1:0] mem_waddr;
    logic [7:0]         mem_wdata;

    assign accept = s_tvalid && s_tready;

    lcwd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .cmd     (s_tuser[0]),
        .in_byte (s_tdata),
        .last    (s_tlast),
        .req     (req),
        .rd_addr (rd_addr)
    );

    lcwd_ram #(
        .WIDTH (8),
        .DEPTH (HIST_DEPTH)
    ) u_history (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lcwd_resolve u_resolve (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .req         (req),
        .rd_addr     (rd_addr),
        .mem_rd_data (rd_data),
        .in_ready    (s_tready),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_kind      (m_tuser),
        .m_byte      (m_tdata)
    );

endmodule
